// File: hw/rtl/lruttl_pkg.sv
// Shared types, constants and a helper function for the LRU cache with expiry.
// Used by lruttl_order and lru_cache_with_ttl; depends on nothing.
`default_nettype none

package lruttl_pkg;

  // Default geometry, handed to the top level as parameter defaults.
  localparam int ENTRIES_DEF    = 16;
  localparam int KEY_BITS_DEF   = 64;
  localparam int VALUE_BITS_DEF = 64;
  localparam int TIME_BITS_DEF  = 40;

  // Fixed field widths.
  localparam int REQ_W = 3;
  localparam int TTL_W = 16;
  localparam int CAP_W = 5;
  localparam int CNT_W = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Request codes.
  typedef enum logic [REQ_W-1:0] {
    REQ_PUT    = 3'd0,
    REQ_GET    = 3'd1,
    REQ_ERASE  = 3'd2,
    REQ_SETEXP = 3'd3,
    REQ_TICK   = 3'd4
  } req_e_t;

  // Commands from the request decoder to the recency tracker.
  typedef struct packed {
    logic evict_lru;    // drop the least recent entry other than the hit
    logic remove_hit;   // drop the entry that matched the key
    logic promote_hit;  // make the matched entry most recent
    logic insert;       // allocate the lowest free slot as most recent
  } ord_ctrl_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c, input logic en);
    logic [CNT_W-1:0] r;
    r = c;
    if (en && (c != {CNT_W{1'b1}})) begin
      r = c + CNT_W'(1);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/lru_cache_with_ttl.sv
// Top level of the fully associative LRU key-value cache with per-entry expiry.
// Depends on lruttl_pkg and instantiates lruttl_match and lruttl_order.
`default_nettype none

// The cache serves one request per clock while no result waits on a stalled
// consumer. A request is captured in an input register; when it is processed,
// a single pass of logic (the key compare across all entries, the rank update
// and the counter increments) commits the new state and loads the result
// register. The rate is set by the associative compare and rank update over
// ENTRIES entries. Every request yields exactly one result: found and data_out
// report a live get hit, evicted flags a capacity or expiry removal, expired
// flags a get on a lapsed entry, and the three totals are the saturating
// counters as they stand after that request. The input side stalls only while
// the result register holds a result that the consumer has not taken. The
// capacity register is written through the cfg port, which is always ready;
// write it only while the cache is idle. A capacity of zero acts as one and a
// value above ENTRIES acts as ENTRIES. After reset all entries are empty at
// once; there is no clearing pass.
module lru_cache_with_ttl #(
  parameter int ENTRIES    = lruttl_pkg::ENTRIES_DEF,
  parameter int KEY_BITS   = lruttl_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = lruttl_pkg::VALUE_BITS_DEF,
  parameter int TIME_BITS  = lruttl_pkg::TIME_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // request channel
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [lruttl_pkg::REQ_W-1:0] in_req_type,
  input  wire logic [KEY_BITS-1:0]          in_key,
  input  wire logic [VALUE_BITS-1:0]        in_data_in,
  input  wire logic [lruttl_pkg::TTL_W-1:0] in_ttl_ticks,
  // result channel
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic                              out_found,
  output logic      [VALUE_BITS-1:0]        out_data_out,
  output logic                              out_evicted,
  output logic                              out_expired,
  output logic      [lruttl_pkg::CNT_W-1:0] out_hit_total,
  output logic      [lruttl_pkg::CNT_W-1:0] out_miss_total,
  output logic      [lruttl_pkg::CNT_W-1:0] out_eviction_total,
  // capacity register write port
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [lruttl_pkg::CAP_W-1:0] cfg_data
);

  localparam int CW   = $clog2(ENTRIES + 1);
  localparam int CMPW = ((CW > lruttl_pkg::CAP_W) ? CW : lruttl_pkg::CAP_W) + 1;

  // Input register.
  logic                         q_vld_r;
  lruttl_pkg::req_e_t           q_req_r;
  logic [KEY_BITS-1:0]          q_key_r;
  logic [VALUE_BITS-1:0]        q_data_r;
  logic [lruttl_pkg::TTL_W-1:0] q_ttl_r;

  // Result register.
  logic                  out_vld_r;
  logic                  found_r, found_nxt;
  logic [VALUE_BITS-1:0] dout_r, dout_nxt;
  logic                  evicted_r, evicted_nxt;
  logic                  expired_r, expired_nxt;

  // Cache state kept here; valid bits and ranks live in the recency tracker.
  logic [lruttl_pkg::CAP_W-1:0] cap_r;
  logic [KEY_BITS-1:0]          key_r   [ENTRIES];
  logic [VALUE_BITS-1:0]        val_r   [ENTRIES];
  logic [TIME_BITS-1:0]         exp_r   [ENTRIES];
  logic [ENTRIES-1:0]           armed_r, armed_nxt;
  logic [TIME_BITS-1:0]         now_r, now_nxt;
  logic [lruttl_pkg::CNT_W-1:0] hit_cnt_r, hit_cnt_nxt;
  logic [lruttl_pkg::CNT_W-1:0] miss_cnt_r, miss_cnt_nxt;
  logic [lruttl_pkg::CNT_W-1:0] evict_cnt_r, evict_cnt_nxt;

  logic                  fire;
  logic                  in_take;
  logic [ENTRIES-1:0]    valid_vec;
  logic [CW-1:0]         count;
  logic [ENTRIES-1:0]    hit_oh;
  logic [ENTRIES-1:0]    rm_oh;
  logic [ENTRIES-1:0]    ins_oh;
  logic                  hit_any;
  lruttl_pkg::ord_ctrl_t ord_ctrl;

  logic [VALUE_BITS-1:0] val_sel;
  logic [TIME_BITS-1:0]  exp_sel;
  logic                  armed_sel;
  logic                  lapsed;
  logic [CMPW-1:0]       cap_ext;
  logic [CMPW-1:0]       cap_eff;
  logic [CMPW-1:0]       after_cnt;
  logic [TIME_BITS:0]    exp_sum;
  logic [TIME_BITS-1:0]  exp_new;
  logic                  do_put;
  logic                  do_setexp;
  logic                  hit_inc;
  logic                  miss_inc;
  logic                  evict_inc;

  // A request is processed when the input register holds one and the result
  // register is empty or is being emptied in this cycle.
  assign fire      = q_vld_r && (!out_vld_r || !out_stall);
  assign in_stall  = q_vld_r && !fire;
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  lruttl_match #(
    .ENTRIES  (ENTRIES),
    .KEY_BITS (KEY_BITS)
  ) u_match (
    .valid_i  (valid_vec),
    .keys_i   (key_r),
    .key_i    (q_key_r),
    .hit_oh_o (hit_oh)
  );

  lruttl_order #(
    .ENTRIES (ENTRIES)
  ) u_order (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl_i   (ord_ctrl),
    .hit_oh_i (hit_oh),
    .valid_o  (valid_vec),
    .count_o  (count),
    .rm_oh_o  (rm_oh),
    .ins_oh_o (ins_oh)
  );

  // Fields of the matching entry, selected by the one-hot compare result.
  always_comb begin
    val_sel   = '0;
    exp_sel   = '0;
    armed_sel = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit_oh[i]) begin
        val_sel   = val_sel | val_r[i];
        exp_sel   = exp_sel | exp_r[i];
        armed_sel = armed_sel | armed_r[i];
      end
    end
  end

  assign hit_any = |hit_oh;
  // An armed entry lapses once the current time is strictly past its expiry.
  assign lapsed  = armed_sel && (now_r > exp_sel);

  // Effective capacity: zero acts as one, anything above ENTRIES as ENTRIES.
  always_comb begin
    cap_ext = CMPW'(cap_r);
    if (cap_ext == '0) begin
      cap_eff = CMPW'(1);
    end else if (cap_ext > CMPW'(ENTRIES)) begin
      cap_eff = CMPW'(ENTRIES);
    end else begin
      cap_eff = cap_ext;
    end
    after_cnt = CMPW'(count) + CMPW'(!hit_any);
  end

  // New expiry time, saturating at the largest representable time.
  always_comb begin
    exp_sum = {1'b0, now_r} + (TIME_BITS + 1)'(q_ttl_r);
    exp_new = exp_sum[TIME_BITS] ? {TIME_BITS{1'b1}} : exp_sum[TIME_BITS-1:0];
  end

  // Request decode. Every action is gated by fire so that idle and stalled
  // cycles leave the state untouched.
  always_comb begin
    ord_ctrl    = '0;
    do_put      = 1'b0;
    do_setexp   = 1'b0;
    hit_inc     = 1'b0;
    miss_inc    = 1'b0;
    evict_inc   = 1'b0;
    found_nxt   = 1'b0;
    dout_nxt    = '0;
    evicted_nxt = 1'b0;
    expired_nxt = 1'b0;
    now_nxt     = now_r;
    if (fire) begin
      case (q_req_r)
        lruttl_pkg::REQ_PUT: begin
          // A put that would push the live count past capacity first drops
          // the least recent entry other than the one being written.
          do_put               = 1'b1;
          ord_ctrl.evict_lru   = after_cnt > cap_eff;
          ord_ctrl.promote_hit = hit_any;
          ord_ctrl.insert      = !hit_any;
          evict_inc            = after_cnt > cap_eff;
          evicted_nxt          = after_cnt > cap_eff;
        end
        lruttl_pkg::REQ_GET: begin
          if (!hit_any) begin
            miss_inc = 1'b1;
          end else if (lapsed) begin
            ord_ctrl.remove_hit = 1'b1;
            miss_inc            = 1'b1;
            evict_inc           = 1'b1;
            evicted_nxt         = 1'b1;
            expired_nxt         = 1'b1;
          end else begin
            ord_ctrl.promote_hit = 1'b1;
            hit_inc              = 1'b1;
            found_nxt            = 1'b1;
            dout_nxt             = val_sel;
          end
        end
        lruttl_pkg::REQ_ERASE: begin
          ord_ctrl.remove_hit = hit_any;
        end
        lruttl_pkg::REQ_SETEXP: begin
          do_setexp = hit_any;
        end
        lruttl_pkg::REQ_TICK: begin
          if (now_r != {TIME_BITS{1'b1}}) begin
            now_nxt = now_r + TIME_BITS'(1);
          end
        end
        default: begin
          // Unknown request codes change nothing and report an empty result.
        end
      endcase
    end
    hit_cnt_nxt   = lruttl_pkg::sat_inc(hit_cnt_r, hit_inc);
    miss_cnt_nxt  = lruttl_pkg::sat_inc(miss_cnt_r, miss_inc);
    evict_cnt_nxt = lruttl_pkg::sat_inc(evict_cnt_r, evict_inc);
  end

  // Expiry arming: a put disarms the written entry, a removal disarms the
  // removed one and a set-expiry arms the matching entry.
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (do_put && (hit_oh[i] || ins_oh[i])) begin
        armed_nxt[i] = 1'b0;
      end else if (rm_oh[i]) begin
        armed_nxt[i] = 1'b0;
      end else if (do_setexp && hit_oh[i]) begin
        armed_nxt[i] = 1'b1;
      end else begin
        armed_nxt[i] = armed_r[i];
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_vld_r     <= 1'b0;
      out_vld_r   <= 1'b0;
      cap_r       <= lruttl_pkg::CAP_RESET;
      armed_r     <= '0;
      now_r       <= '0;
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      evict_cnt_r <= '0;
    end else begin
      if (in_take) begin
        q_vld_r <= 1'b1;
      end else if (fire) begin
        q_vld_r <= 1'b0;
      end
      if (fire) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_data;
      end
      armed_r     <= armed_nxt;
      now_r       <= now_nxt;
      hit_cnt_r   <= hit_cnt_nxt;
      miss_cnt_r  <= miss_cnt_nxt;
      evict_cnt_r <= evict_cnt_nxt;
    end
  end

  // Payload: request capture, result capture and entry contents.
  always_ff @(posedge clk) begin
    if (in_take) begin
      q_req_r  <= lruttl_pkg::req_e_t'(in_req_type);
      q_key_r  <= in_key;
      q_data_r <= in_data_in;
      q_ttl_r  <= in_ttl_ticks;
    end
    if (fire) begin
      found_r   <= found_nxt;
      dout_r    <= dout_nxt;
      evicted_r <= evicted_nxt;
      expired_r <= expired_nxt;
    end
    for (int i = 0; i < ENTRIES; i++) begin
      if (do_put && ins_oh[i]) begin
        key_r[i] <= q_key_r;
      end
      if (do_put && (hit_oh[i] || ins_oh[i])) begin
        val_r[i] <= q_data_r;
      end
      if (do_setexp && hit_oh[i]) begin
        exp_r[i] <= exp_new;
      end
    end
  end

  // The counters change only when a request is processed, which needs a free
  // result register, so they hold steady while a result waits.
  assign out_valid          = out_vld_r;
  assign out_found          = found_r;
  assign out_data_out       = dout_r;
  assign out_evicted        = evicted_r;
  assign out_expired        = expired_r;
  assign out_hit_total      = hit_cnt_r;
  assign out_miss_total     = miss_cnt_r;
  assign out_eviction_total = evict_cnt_r;

endmodule

`default_nettype wire

// File: hw/rtl/lruttl_match.sv
// Associative key compare of the LRU cache: one comparator per entry.
// Uses no package items; instantiated by lru_cache_with_ttl.
`default_nettype none

module lruttl_match #(
  parameter int ENTRIES  = 16,
  parameter int KEY_BITS = 64
) (
  input  wire logic [ENTRIES-1:0]  valid_i,
  input  wire logic [KEY_BITS-1:0] keys_i [ENTRIES],
  input  wire logic [KEY_BITS-1:0] key_i,
  output logic      [ENTRIES-1:0]  hit_oh_o
);

  // Keys of valid entries are unique, so at most one bit is set.
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      hit_oh_o[i] = valid_i[i] && (keys_i[i] == key_i);
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/lruttl_order.sv
// Recency tracker: entry valid bits, recency ranks and the live entry count.
// Depends on lruttl_pkg for the command struct; instantiated by lru_cache_with_ttl.
`default_nettype none

module lruttl_order #(
  parameter int ENTRIES = 16,
  localparam int RW = $clog2(ENTRIES),
  localparam int CW = $clog2(ENTRIES + 1)
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire lruttl_pkg::ord_ctrl_t ctrl_i,
  input  wire logic [ENTRIES-1:0]    hit_oh_i,
  output logic      [ENTRIES-1:0]    valid_o,
  output logic      [CW-1:0]         count_o,
  output logic      [ENTRIES-1:0]    rm_oh_o,
  output logic      [ENTRIES-1:0]    ins_oh_o
);

  logic [ENTRIES-1:0] valid_r, valid_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [RW-1:0]      rank_r   [ENTRIES];
  logic [RW-1:0]      rank_nxt [ENTRIES];
  logic [RW-1:0]      rank_mid [ENTRIES];

  logic               hit_any;
  logic [RW-1:0]      rank_hit;
  logic [RW-1:0]      rank_hit_mid;
  logic [RW-1:0]      rank_rm;
  logic [CW-1:0]      last_cnt;
  logic [RW-1:0]      last_rank;
  logic [RW-1:0]      tgt_rank;
  logic [ENTRIES-1:0] victim_oh;
  logic [ENTRIES-1:0] rm_oh;
  logic [ENTRIES-1:0] valid_mid;
  logic [ENTRIES-1:0] free_vec;
  logic [ENTRIES-1:0] ins_oh;
  logic               rm_any;

  // Valid ranks always form 0..count-1, so the least recent entry other than
  // the hit has rank count-1, or count-2 when the hit itself holds count-1.
  always_comb begin
    hit_any  = |hit_oh_i;
    rank_hit = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit_oh_i[i]) begin
        rank_hit = rank_hit | rank_r[i];
      end
    end
    last_cnt  = count_r - CW'(1);
    last_rank = last_cnt[RW-1:0];
    tgt_rank  = (hit_any && (rank_hit == last_rank)) ? (last_rank - RW'(1)) : last_rank;

    for (int i = 0; i < ENTRIES; i++) begin
      victim_oh[i] = valid_r[i] && !hit_oh_i[i] && (rank_r[i] == tgt_rank);
    end

    if (ctrl_i.evict_lru) begin
      rm_oh = victim_oh;
    end else if (ctrl_i.remove_hit) begin
      rm_oh = hit_oh_i;
    end else begin
      rm_oh = '0;
    end
    rm_any = |rm_oh;

    rank_rm = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (rm_oh[i]) begin
        rank_rm = rank_rm | rank_r[i];
      end
    end

    // Removal closes the gap above the removed rank.
    for (int i = 0; i < ENTRIES; i++) begin
      rank_mid[i] = rank_r[i] -
                    RW'(rm_any && valid_r[i] && !rm_oh[i] && (rank_r[i] > rank_rm));
    end
    valid_mid = valid_r & ~rm_oh;

    rank_hit_mid = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit_oh_i[i]) begin
        rank_hit_mid = rank_hit_mid | rank_mid[i];
      end
    end

    // Lowest free slot after the removal.
    free_vec = ~valid_mid;
    ins_oh   = ctrl_i.insert ? (free_vec & (~free_vec + ENTRIES'(1))) : '0;

    for (int i = 0; i < ENTRIES; i++) begin
      if (ctrl_i.promote_hit) begin
        rank_nxt[i] = hit_oh_i[i] ? '0 :
                      rank_mid[i] + RW'(valid_mid[i] && (rank_mid[i] < rank_hit_mid));
      end else if (ctrl_i.insert) begin
        rank_nxt[i] = ins_oh[i] ? '0 : rank_mid[i] + RW'(valid_mid[i]);
      end else begin
        rank_nxt[i] = rank_mid[i];
      end
    end

    valid_nxt = valid_mid | ins_oh;
    count_nxt = count_r - CW'(rm_any) + CW'(|ins_oh);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      count_r <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_r[i] <= '0;
      end
    end else begin
      valid_r <= valid_nxt;
      count_r <= count_nxt;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_r[i] <= rank_nxt[i];
      end
    end
  end

  assign valid_o  = valid_r;
  assign count_o  = count_r;
  assign rm_oh_o  = rm_oh;
  assign ins_oh_o = ins_oh;

endmodule

`default_nettype wire

// File: tb/cache_shadow_pkg.sv
`timescale 1ns / 100ps
// Scoreboard for the LRU cache with expiry: a shadow copy of the cache that predicts
// each response, plus the queue of responses the design still owes. Uses lruttl_pkg.
package cache_shadow_pkg;
  import lruttl_pkg::*;

  localparam int SLOTS = ENTRIES_DEF;
  localparam int KW    = KEY_BITS_DEF;
  localparam int VW    = VALUE_BITS_DEF;
  localparam int TW    = TIME_BITS_DEF;

  typedef struct packed {
    logic             found;
    logic [VW-1:0]    data_out;
    logic             evicted;
    logic             expired;
    logic [CNT_W-1:0] hit_total;
    logic [CNT_W-1:0] miss_total;
    logic [CNT_W-1:0] eviction_total;
  } cache_resp_t;

  class cache_shadow;
    bit             live     [SLOTS];
    bit [KW-1:0]    tag      [SLOTS];
    bit [VW-1:0]    word     [SLOTS];
    int unsigned    age      [SLOTS];  // 0 is the most recently used live entry
    bit             armed    [SLOTS];
    bit [TW-1:0]    deadline [SLOTS];
    bit [TW-1:0]    now;
    bit [CNT_W-1:0] hits, misses, evictions;
    bit [CAP_W-1:0] cap_reg;
    cache_resp_t    owed[$];
    int unsigned    requests, expired_gets, failures;

    function new();
      cap_reg = CAP_RESET;
    endfunction

    function int pending();
      return owed.size();
    endfunction

    function bit [CNT_W-1:0] sat_up(bit [CNT_W-1:0] c);
      return (c == '1) ? c : c + 1'b1;
    endfunction

    function void drop_slot(int s);
      foreach (live[i]) begin
        if (live[i] && i != s && age[i] > age[s]) age[i]--;
      end
      live[s]  = 1'b0;
      armed[s] = 1'b0;
      age[s]   = 0;
    endfunction

    function void promote_slot(int s);
      foreach (live[i]) begin
        if (live[i] && i != s && age[i] < age[s]) age[i]++;
      end
      age[s] = 0;
    endfunction

    // Updates the shadow state for one accepted request and queues its response.
    function void apply_request(logic [REQ_W-1:0] req, logic [KW-1:0] k,
                                logic [VW-1:0] d, logic [TTL_W-1:0] ttl);
      cache_resp_t r;
      int          limit, hit, victim, count;
      bit [TW:0]   sum;
      r     = '0;
      limit = (cap_reg == 0) ? 1 : (cap_reg > SLOTS) ? SLOTS : int'(cap_reg);
      hit   = -1;
      count = 0;
      foreach (live[i]) begin
        if (live[i]) count++;
        if (hit < 0 && live[i] && tag[i] == k) hit = i;
      end
      case (req)
        REQ_PUT: begin
          if (count + ((hit < 0) ? 1 : 0) > limit) begin
            victim = -1;
            foreach (live[i]) begin
              if (live[i] && i != hit && (victim < 0 || age[i] > age[victim])) victim = i;
            end
            if (victim >= 0) begin
              drop_slot(victim);
              evictions = sat_up(evictions);
              r.evicted = 1'b1;
            end
          end
          if (hit >= 0) begin
            promote_slot(hit);
          end else begin
            foreach (live[i]) begin
              if (hit < 0 && !live[i]) hit = i;
            end
            foreach (live[i]) begin
              if (live[i]) age[i]++;
            end
            live[hit] = 1'b1;
            tag[hit]  = k;
            age[hit]  = 0;
          end
          word[hit]     = d;
          armed[hit]    = 1'b0;
          deadline[hit] = '0;
        end
        REQ_GET: begin
          if (hit < 0) begin
            misses = sat_up(misses);
          end else if (armed[hit] && now > deadline[hit]) begin
            drop_slot(hit);
            misses    = sat_up(misses);
            evictions = sat_up(evictions);
            r.evicted = 1'b1;
            r.expired = 1'b1;
            expired_gets++;
          end else begin
            promote_slot(hit);
            r.found    = 1'b1;
            r.data_out = word[hit];
            hits       = sat_up(hits);
          end
        end
        REQ_ERASE: begin
          if (hit >= 0) drop_slot(hit);
        end
        REQ_SETEXP: begin
          if (hit >= 0) begin
            sum           = {1'b0, now} + ttl;
            armed[hit]    = 1'b1;
            deadline[hit] = sum[TW] ? '1 : sum[TW-1:0];
          end
        end
        REQ_TICK: begin
          if (now != '1) now++;
        end
        default: ;
      endcase
      r.hit_total      = hits;
      r.miss_total     = misses;
      r.eviction_total = evictions;
      owed.push_back(r);
      requests++;
    endfunction

    function void check_response(cache_resp_t got);
      cache_resp_t want;
      if (owed.size() == 0) begin
        $error("response arrived with no request outstanding");
        failures++;
        return;
      end
      want = owed.pop_front();
      if (got.found !== want.found) begin
        $error("found: expected %0d, got %0d", want.found, got.found);
        failures++;
      end
      if (got.data_out !== want.data_out) begin
        $error("data_out: expected %h, got %h", want.data_out, got.data_out);
        failures++;
      end
      if (got.evicted !== want.evicted) begin
        $error("evicted: expected %0d, got %0d", want.evicted, got.evicted);
        failures++;
      end
      if (got.expired !== want.expired) begin
        $error("expired: expected %0d, got %0d", want.expired, got.expired);
        failures++;
      end
      if (got.hit_total !== want.hit_total) begin
        $error("hit_total: expected %0d, got %0d", want.hit_total, got.hit_total);
        failures++;
      end
      if (got.miss_total !== want.miss_total) begin
        $error("miss_total: expected %0d, got %0d", want.miss_total, got.miss_total);
        failures++;
      end
      if (got.eviction_total !== want.eviction_total) begin
        $error("eviction_total: expected %0d, got %0d", want.eviction_total,
               got.eviction_total);
        failures++;
      end
    endfunction
  endclass

endpackage

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// Top-level testbench for lru_cache_with_ttl: drives requests and capacity writes,
// checks every response against cache_shadow_pkg. Needs lruttl_pkg and the RTL.
module tb_top;
  import lruttl_pkg::*;
  import cache_shadow_pkg::*;

  // Request codes the design does not define; they must leave all state alone.
  localparam logic [REQ_W-1:0] REQ_UNUSED_FIRST = 3'd5;
  localparam logic [REQ_W-1:0] REQ_UNUSED_LAST  = 3'd7;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 169;
  localparam int KEY_POOL    = 24;
  localparam int CYCLE_LIMIT = 200000;

  logic             clk          = 1'b0;
  logic             rst_n        = 1'b0;
  logic             in_valid     = 1'b0;
  logic [REQ_W-1:0] in_req_type  = '0;
  logic [KW-1:0]    in_key       = '0;
  logic [VW-1:0]    in_data_in   = '0;
  logic [TTL_W-1:0] in_ttl_ticks = '0;
  logic             out_stall    = 1'b0;
  logic             cfg_valid    = 1'b0;
  logic [CAP_W-1:0] cfg_data     = '0;
  logic             in_stall, out_valid, cfg_ready;
  logic             out_found, out_evicted, out_expired;
  logic [VW-1:0]    out_data_out;
  logic [CNT_W-1:0] out_hit_total, out_miss_total, out_eviction_total;

  cache_shadow      shadow;
  logic [KW-1:0]    key_pool [KEY_POOL];
  // Capacity for each random phase: the reset value, both clamped corners, and a
  // few middle sizes. Going from 16 straight to 1 leaves the cache over capacity.
  logic [CAP_W-1:0] cap_plan [PHASES] = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd3, 5'd8, 5'd2, 5'd16};
  int               send_pct  = 0;   // chance per cycle that the sender sits idle
  int               stall_pct = 0;   // chance per cycle that the receiver stalls
  int               hold_ask  = 0;   // long receiver hold-off requested by the sequence
  int               hold_left = 0;
  int unsigned      cycle_count = 0;

  lru_cache_with_ttl dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_req_type       (in_req_type),
    .in_key            (in_key),
    .in_data_in        (in_data_in),
    .in_ttl_ticks      (in_ttl_ticks),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_found         (out_found),
    .out_data_out      (out_data_out),
    .out_evicted       (out_evicted),
    .out_expired       (out_expired),
    .out_hit_total     (out_hit_total),
    .out_miss_total    (out_miss_total),
    .out_eviction_total(out_eviction_total),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // The run is cut off here if the design hangs; a correct run ends far sooner.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Receiver. A long hold-off, once requested, is counted down here one cycle at a
  // time and overrides the random stall pattern of the current phase.
  always @(negedge clk) begin
    if (hold_ask != 0) begin
      hold_left = hold_ask;
      hold_ask  = 0;
    end
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Every response taken by the receiver is checked against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      shadow.check_response({out_found, out_data_out, out_evicted, out_expired,
                             out_hit_total, out_miss_total, out_eviction_total});
    end
  end

  // Offers one request and returns at the edge where it is accepted. Idle gaps
  // come only before the request is raised, so valid never reacts to the stall.
  task automatic send_request(input logic [REQ_W-1:0] rq, input logic [KW-1:0] k,
                              input logic [VW-1:0] d, input logic [TTL_W-1:0] t);
    @(negedge clk);
    while ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_req_type  <= rq;
    in_key       <= k;
    in_data_in   <= d;
    in_ttl_ticks <= t;
    do @(posedge clk); while (in_stall);
    shadow.apply_request(rq, k, d, t);
  endtask

  // Drops valid and waits until every predicted response has been taken.
  task automatic drain_requests();
    @(negedge clk);
    in_valid <= 1'b0;
    while (shadow.pending() != 0) @(posedge clk);
  endtask

  // Capacity writes happen only with the cache drained. Every request produces a
  // response, so an empty prediction queue means the design is idle.
  task automatic write_capacity(input logic [CAP_W-1:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    shadow.cap_reg = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [REQ_W-1:0] rq;
    logic [KW-1:0]    k;
    logic [VW-1:0]    d;
    logic [TTL_W-1:0] t;
    int               roll, mode;
    shadow = new();
    // A small key pool keeps hits, expiries and evictions frequent. The first two
    // keys are the all-zero and all-one corners.
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < KEY_POOL; i++) key_pool[i] = {$urandom, $urandom};
    cap_plan[6] = CAP_W'($urandom_range(15, 2));

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part, with room for only two entries so that eviction shows up.
    write_capacity(5'd2);
    send_request(REQ_PUT, key_pool[0], '1, '0);
    send_request(REQ_PUT, key_pool[1], '0, '1);
    send_request(REQ_GET, key_pool[0], '0, '0);
    send_request(REQ_GET, key_pool[1], '1, '0);
    send_request(REQ_GET, 64'h5a5a_a5a5_0ff0_f00f, '0, '0);      // absent key misses
    send_request(REQ_ERASE, 64'h5a5a_a5a5_0ff0_f00f, '0, '0);    // erase of absent key
    send_request(REQ_SETEXP, 64'h5a5a_a5a5_0ff0_f00f, '0, 16'd9); // expiry of absent key
    send_request(REQ_SETEXP, key_pool[0], '0, 16'd0);
    // Expiry equal to the current time is still live; one tick later it lapses.
    send_request(REQ_GET, key_pool[0], '0, '0);
    send_request(REQ_TICK, '1, '1, '1);
    send_request(REQ_GET, key_pool[0], '0, '0);
    send_request(REQ_GET, key_pool[0], '0, '0);
    send_request(REQ_PUT, key_pool[2], 64'h0123_4567_89ab_cdef, '0);
    send_request(REQ_PUT, key_pool[3], 64'hfedc_ba98_7654_3210, '0); // full: LRU goes
    send_request(REQ_GET, key_pool[1], '0, '0);
    send_request(REQ_SETEXP, key_pool[2], '0, '1);
    send_request(REQ_TICK, '0, '0, '0);
    send_request(REQ_GET, key_pool[2], '0, '0);
    send_request(REQ_PUT, key_pool[2], 64'h8000_0000_0000_0001, '0); // replace, disarm
    send_request(REQ_ERASE, key_pool[3], '0, '0);
    send_request(REQ_GET, key_pool[3], '0, '0);
    for (int u = REQ_UNUSED_FIRST; u <= REQ_UNUSED_LAST; u++) begin
      send_request(REQ_W'(u), key_pool[2], {$urandom, $urandom}, 16'($urandom));
    end
    drain_requests();

    // Random phases. The idle pattern rotates through none, sender only, receiver
    // only and both, while the capacity walks through cap_plan.
    for (int p = 0; p < PHASES; p++) begin
      write_capacity(cap_plan[p]);
      mode      = p % 4;
      send_pct  = (mode == 1) ? 62 : (mode == 3) ? 17 : 0;
      stall_pct = (mode == 2) ? 62 : (mode == 3) ? 17 : 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        roll = $urandom_range(99);
        if (roll < 30)      rq = REQ_PUT;
        else if (roll < 62) rq = REQ_GET;
        else if (roll < 70) rq = REQ_ERASE;
        else if (roll < 80) rq = REQ_SETEXP;
        else if (roll < 94) rq = REQ_TICK;
        else                rq = REQ_W'($urandom_range(REQ_UNUSED_LAST, REQ_UNUSED_FIRST));
        k    = ($urandom_range(9) == 0) ? {$urandom, $urandom}
                                        : key_pool[$urandom_range(KEY_POOL - 1)];
        roll = $urandom_range(19);
        d    = (roll == 0) ? '0 : (roll == 1) ? '1 : {$urandom, $urandom};
        // Mostly short lifetimes so that entries actually lapse between ticks.
        t    = ($urandom_range(9) < 7) ? 16'($urandom_range(6)) : 16'($urandom);
        send_request(rq, k, d, t);
        // With no idling in phase 0, a long receiver hold-off backs the cache up
        // until it stalls its input while the sender keeps offering.
        if (p == 0 && n == 50) hold_ask = 60;
        // In phase 4 the sender stops once and lets every response come home.
        if (p == 4 && n == 90) drain_requests();
      end
      drain_requests();
    end

    repeat (10) @(posedge clk);
    $display("Covered %0d requests across %0d capacity settings and four idle patterns.",
             shadow.requests, PHASES + 1);
    $display("Gets: %0d hits, %0d misses (%0d on lapsed entries); %0d evictions in all.",
             shadow.hits, shadow.misses, shadow.expired_gets, shadow.evictions);
    if (shadow.failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
